FILE: rtl/core/lbcd_pkg.sv
// Shared types and constants for the block cache directory.
// Used by the front end, the request queue, the back end and the top level.
package lbcd_pkg;

   localparam int DEFAULT_ENTRIES = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int REQ_TYPE_W      = 2;
   localparam int ID_W            = 32;
   localparam int SIZE_W          = 32;
   localparam int RSP_SLOT_W      = 4;
   localparam int REQ_TDATA_W     = ID_W + SIZE_W;
   localparam int RSP_TDATA_W     = 40;

   localparam logic [SIZE_W-1:0] DEFAULT_SIZE_RESET = 32'h0001_0000;

   // Request type codes as they arrive on the bus
   localparam logic [REQ_TYPE_W-1:0] REQ_ACCESS = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_SET    = 2'd2;

   typedef enum logic [1:0] {
      OP_ACCESS,
      OP_QUERY,
      OP_SET
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [ID_W-1:0]   blk_tag;
      logic [SIZE_W-1:0] new_size;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

endpackage

FILE: rtl/core/lbcd_front.sv
// Front end: accepts requests and decodes the request type into an operation.
// Depends on lbcd_pkg; feeds lbcd_cmd_fifo.
module lbcd_front (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lbcd_pkg::REQ_TDATA_W-1:0] req_tdata,  // block id, new_size
   input  logic [lbcd_pkg::REQ_TYPE_W-1:0]  req_tuser,  // req_type
   input  lbcd_pkg::q_status_type          q_status,
   output logic                            push,
   output lbcd_pkg::cmd_type               push_cmd
);
   import lbcd_pkg::*;

   op_type op;

   always_comb begin
      unique case (req_tuser)
         REQ_ACCESS: op = OP_ACCESS;
         REQ_QUERY:  op = OP_QUERY;
         REQ_SET:    op = OP_SET;
         default:    op = OP_QUERY;   // unused code behaves as a size query
      endcase
   end

   assign req_tready        = !q_status.full;
   assign push              = req_tvalid && !q_status.full;
   assign push_cmd.op       = op;
   assign push_cmd.blk_tag  = req_tdata[ID_W-1:0];
   assign push_cmd.new_size = req_tdata[ID_W+SIZE_W-1:ID_W];

endmodule

FILE: rtl/core/lbcd_cmd_fifo.sv
// Short request queue between the front end and the back end.
// Depends on lbcd_pkg for the command type and queue depth.
module lbcd_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lbcd_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output lbcd_pkg::cmd_type      pop_cmd,
   output lbcd_pkg::q_status_type status
);
   import lbcd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_cmd      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/core/lbcd_back.sv
// Back end: directory entries, tag lookup, LRU update and the response register.
// Depends on lbcd_pkg; takes commands from lbcd_cmd_fifo.
module lbcd_back #(
   parameter int ENTRIES = lbcd_pkg::DEFAULT_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [lbcd_pkg::SIZE_W-1:0]      csr_wdata,
   input  lbcd_pkg::cmd_type                q_cmd,
   input  lbcd_pkg::q_status_type           q_status,
   output logic                             q_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [lbcd_pkg::RSP_SLOT_W-1:0]  rsp_slot,
   output logic [lbcd_pkg::SIZE_W-1:0]      rsp_size
);
   import lbcd_pkg::*;

   localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = SLOT_W;
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   state_type         state_ff, state_in;
   cmd_type           cmd_ff;
   logic              valid_ff [ENTRIES];
   logic              valid_in [ENTRIES];
   logic [ID_W-1:0]   block_ff [ENTRIES];
   logic [ID_W-1:0]   block_in [ENTRIES];
   logic [SIZE_W-1:0] len_ff   [ENTRIES];
   logic [SIZE_W-1:0] len_in   [ENTRIES];
   logic [RANK_W-1:0] rank_ff  [ENTRIES];
   logic [RANK_W-1:0] rank_in  [ENTRIES];
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [SIZE_W-1:0] default_size_ff, default_size_in;

   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] tgt_ff, tgt_in;
   logic [RANK_W:0]   old_rank_ff, old_rank_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [RSP_SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [SIZE_W-1:0] rsp_size_ff, rsp_size_in;

   logic              load_cmd, lookup_en, commit, out_free, full;
   logic              m_found;
   logic [SLOT_W-1:0] m_idx, v_idx, free_idx;
   logic [CNT_W-1:0]  free_cnt;
   logic [SLOT_W+RSP_SLOT_W-1:0] slot_wide;
   logic [SIZE_W-1:0] tgt_len;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign full     = (fill_ff == CNT_W'(ENTRIES));
   assign free_cnt = CNT_W'(ENTRIES - 1) - fill_ff;
   assign free_idx = free_cnt[SLOT_W-1:0];
   assign tgt_len  = len_ff[tgt_ff];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (!q_status.empty) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (out_free) state_in = q_status.empty ? ST_IDLE : ST_LOOKUP;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      lookup_en = 1'b0;
      commit    = 1'b0;
      load_cmd  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   load_cmd = !q_status.empty;
         ST_LOOKUP: lookup_en = 1'b1;
         ST_UPDATE: begin
            commit   = out_free;
            load_cmd = out_free && !q_status.empty;
         end
         default: ;
      endcase
   end

   assign q_pop = load_cmd;

   // Parallel tag compare, lowest matching slot wins
   always_comb begin
      m_found = 1'b0;
      m_idx   = '0;
      v_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && block_ff[i] == cmd_ff.blk_tag) begin
            m_found = 1'b1;
            m_idx   = SLOT_W'(i);
         end
         if (valid_ff[i] && rank_ff[i] == RANK_W'(ENTRIES - 1)) begin
            v_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      hit_in      = hit_ff;
      tgt_in      = tgt_ff;
      old_rank_in = old_rank_ff;
      if (lookup_en) begin
         hit_in = m_found;
         if (m_found) begin
            tgt_in      = m_idx;
            old_rank_in = {1'b0, rank_ff[m_idx]};
         end else if (cmd_ff.op != OP_ACCESS) begin
            tgt_in      = '0;
            old_rank_in = '0;
         end else if (!full) begin
            tgt_in      = free_idx;
            old_rank_in = (RANK_W+1)'(ENTRIES);
         end else begin
            tgt_in      = v_idx;
            old_rank_in = (RANK_W+1)'(ENTRIES - 1);
         end
      end
   end

   // Directory update
   always_comb begin
      fill_in = fill_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         block_in[i] = block_ff[i];
         len_in[i]   = len_ff[i];
         rank_in[i]  = rank_ff[i];
         if (commit && cmd_ff.op == OP_ACCESS) begin
            if (tgt_ff == SLOT_W'(i)) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
               if (!hit_ff) begin
                  block_in[i] = cmd_ff.blk_tag;
                  len_in[i]   = default_size_ff;
               end
            end else if (valid_ff[i] && {1'b0, rank_ff[i]} < old_rank_ff) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
         if (commit && cmd_ff.op == OP_SET && hit_ff && tgt_ff == SLOT_W'(i)) begin
            len_in[i] = cmd_ff.new_size;
         end
      end
      if (commit && cmd_ff.op == OP_ACCESS && !hit_ff && !full) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   // Response register
   always_comb begin
      slot_wide    = {{RSP_SLOT_W{1'b0}}, tgt_ff};
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_size_in  = rsp_size_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         rsp_slot_in  = slot_wide[RSP_SLOT_W-1:0];
         case (cmd_ff.op)
            OP_ACCESS: rsp_size_in = hit_ff ? tgt_len : default_size_ff;
            OP_SET:    rsp_size_in = hit_ff ? cmd_ff.new_size : '0;
            default:   rsp_size_in = hit_ff ? tgt_len : '0;
         endcase
      end
   end

   assign default_size_in = csr_we ? csr_wdata : default_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         fill_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         default_size_ff <= DEFAULT_SIZE_RESET;
         for (int i = 0; i < ENTRIES; i++) valid_ff[i] <= 1'b0;
      end else begin
         state_ff        <= state_in;
         fill_ff         <= fill_in;
         rsp_valid_ff    <= rsp_valid_in;
         default_size_ff <= default_size_in;
         for (int i = 0; i < ENTRIES; i++) valid_ff[i] <= valid_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (load_cmd) cmd_ff <= q_cmd;
      hit_ff      <= hit_in;
      tgt_ff      <= tgt_in;
      old_rank_ff <= old_rank_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_size_ff <= rsp_size_in;
      for (int i = 0; i < ENTRIES; i++) begin
         block_ff[i] <= block_in[i];
         len_ff[i]   <= len_in[i];
         rank_ff[i]  <= rank_in[i];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_size  = rsp_size_ff;

`ifndef SYNTHESIS
   logic [ENTRIES-1:0] valid_vec;
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) valid_vec[i] = valid_ff[i];
   end

   a_fill_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(fill_ff))
      else $error("fill count differs from number of valid slots");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(ENTRIES))
      else $error("fill count beyond directory size");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_UPDATE)
      else $error("response raised outside update");

   a_hit_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      commit && hit_ff |=> $stable(fill_ff))
      else $error("hit changed fill count");
`endif

endmodule

FILE: rtl/core/lru_block_cache_directory.sv
// Fully associative block directory with LRU replacement.
// A request passes through the queue, then the lookup and update states of the back end,
// before its response is valid. The back end takes one request at a time through lookup
// then update, sharing the directory registers; the queue holds requests meanwhile.
// Reset: synchronous, active high; empties the directory and the queue,
// and loads the default size register with 65536.
module lru_block_cache_directory #(
   parameter int ENTRIES = lbcd_pkg::DEFAULT_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lbcd_pkg::REQ_TDATA_W-1:0] req_tdata,  // block id, new_size
   input  logic [lbcd_pkg::REQ_TYPE_W-1:0]  req_tuser,  // req_type
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lbcd_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // slot, entry_size, zero pad
   output logic                             rsp_tuser,  // hit
   input  logic                             csr_we,
   input  logic [lbcd_pkg::SIZE_W-1:0]      csr_wdata
);
   import lbcd_pkg::*;

   q_status_type           q_status;
   cmd_type                push_cmd, pop_cmd;
   logic                   push, pop;
   logic [RSP_SLOT_W-1:0]  slot;
   logic [SIZE_W-1:0]      entry_size;

   lbcd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   lbcd_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   lbcd_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_cmd     (pop_cmd),
      .q_status  (q_status),
      .q_pop     (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_hit   (rsp_tuser),
      .rsp_slot  (slot),
      .rsp_size  (entry_size)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_SLOT_W - SIZE_W){1'b0}}, entry_size, slot};

endmodule
